@@ hdl/rti_pkg.sv @@
package rti_pkg;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int CW = CB + 1;
  localparam int W = 4 * CW + 4;

  localparam int MUL_DIG = (CW + 7) / 8;
  localparam int MAW = MUL_DIG * 8;
  localparam int MCW = $clog2(MUL_DIG + 1);
  localparam int DCW = $clog2(CB + 1);

  localparam int QDEPTH = 2;
  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;
  localparam logic [1:0] SLOT_NONE = 2'd3;

  localparam logic CFG_TMIN = 1'b0;
  localparam logic CFG_TMAX = 1'b1;

  // determinant slots and column codes
  localparam logic [1:0] DET_BETA = 2'd0;
  localparam logic [1:0] DET_GAMMA = 2'd1;
  localparam logic [1:0] DET_T = 2'd2;
  localparam logic [1:0] DET_A = 2'd3;
  localparam logic [1:0] COL_D = 2'd2;
  localparam logic [1:0] COL_AE = 2'd3;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [CW-1:0] col_t;
  typedef logic signed [W-1:0] wide_t;

  localparam logic [63:0] TMAX_WIDE = 64'd1000 << FB;
  localparam coord_t TMAX_RST = TMAX_WIDE[CB-1:0];

  typedef struct packed {
    logic                     is_test;
    logic [3:0][2:0][CW-1:0]  col;
    logic [2:0][CB-1:0]       pos;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DET, S_DETW, S_SIGN, S_LIM, S_LIMW, S_CHECK,
    S_DIV, S_DIVW, S_HPT, S_HPTW, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_P, PH_Q, PH_T} phase_t;

  function automatic col_t cext(input coord_t v);
    return {v[CB-1], v};
  endfunction

  function automatic wide_t wext(input col_t v);
    return {{(W-CW){v[CW-1]}}, v};
  endfunction

  function automatic coord_t sat(input wide_t v);
    wide_t hi;
    wide_t lo;
    coord_t r;
    hi = '0;
    hi[CB-2:0] = '1;
    lo = ~hi;
    if (v > hi) r = {1'b0, {(CB-1){1'b1}}};
    else if (v < lo) r = {1'b1, {(CB-1){1'b0}}};
    else r = v[CB-1:0];
    return r;
  endfunction

endpackage

@@ hdl/rti_front.sv @@
module rti_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  logic [1:0]        vertex_slot,
  input  rti_pkg::coord_t   pos_x,
  input  rti_pkg::coord_t   pos_y,
  input  rti_pkg::coord_t   pos_z,
  input  rti_pkg::coord_t   dir_x,
  input  rti_pkg::coord_t   dir_y,
  input  rti_pkg::coord_t   dir_z,
  input  logic              full,
  output logic              busy,
  output logic              push,
  output rti_pkg::entry_t   ent
);

  logic [8:0][rti_pkg::CB-1:0] vstore;
  logic [2:0][rti_pkg::CB-1:0] pos_v;
  logic [2:0][rti_pkg::CB-1:0] dir_v;

  assign pos_v = {pos_z, pos_y, pos_x};
  assign dir_v = {dir_z, dir_y, dir_x};
  assign busy = full;
  assign push = start && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vstore <= '0;
    end else if (push && opcode == rti_pkg::OP_LOAD) begin
      case (vertex_slot)
        rti_pkg::SLOT_A: vstore[2:0] <= pos_v;
        rti_pkg::SLOT_B: vstore[5:3] <= pos_v;
        rti_pkg::SLOT_C: vstore[8:6] <= pos_v;
        default: ;
      endcase
    end
  end

  // columns a-b, a-c, d, a-e
  always_comb begin
    ent.is_test = (opcode == rti_pkg::OP_TEST);
    ent.pos = pos_v;
    for (int k = 0; k < 3; k++) begin
      ent.col[0][k] = rti_pkg::cext(vstore[k]) - rti_pkg::cext(vstore[3+k]);
      ent.col[1][k] = rti_pkg::cext(vstore[k]) - rti_pkg::cext(vstore[6+k]);
      ent.col[2][k] = rti_pkg::cext(dir_v[k]);
      ent.col[3][k] = rti_pkg::cext(vstore[k]) - rti_pkg::cext(pos_v[k]);
    end
  end

endmodule

@@ hdl/rti_queue.sv @@
module rti_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rti_pkg::entry_t  din,
  input  logic             pop,
  output rti_pkg::entry_t  dout,
  output logic             full,
  output logic             empty
);

  rti_pkg::entry_t mem [rti_pkg::QDEPTH];
  logic [rti_pkg::QPW-1:0] wp;
  logic [rti_pkg::QPW-1:0] rp;
  logic [rti_pkg::QCW-1:0] cnt;

  assign full = (cnt == rti_pkg::QCW'(rti_pkg::QDEPTH));
  assign empty = (cnt == '0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ hdl/rti_mul.sv @@
module rti_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  rti_pkg::col_t   a,
  input  rti_pkg::wide_t  b,
  output logic            done,
  output rti_pkg::wide_t  prod
);

  // MSB-first radix-256 digits of a; top digit signed
  logic                     run;
  logic [rti_pkg::MCW-1:0]  cnt;
  logic [rti_pkg::MAW-1:0]  ash;
  rti_pkg::wide_t           bop;
  rti_pkg::wide_t           acc;
  logic [7:0]               dig;
  logic signed [8:0]        dext;
  logic signed [rti_pkg::W+8:0] pp;

  assign dig = ash[rti_pkg::MAW-1 -: 8];
  assign dext = (cnt == rti_pkg::MCW'(rti_pkg::MUL_DIG)) ? {dig[7], dig} : {1'b0, dig};
  assign pp = dext * bop;
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (go) begin
      ash <= {{(rti_pkg::MAW-rti_pkg::CW){a[rti_pkg::CW-1]}}, a};
      bop <= b;
      acc <= '0;
      cnt <= rti_pkg::MCW'(rti_pkg::MUL_DIG);
    end else if (run) begin
      ash <= ash << 8;
      acc <= (acc <<< 8) + pp[rti_pkg::W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && cnt == rti_pkg::MCW'(1);
      if (go) run <= 1'b1;
      else if (run && cnt == rti_pkg::MCW'(1)) run <= 1'b0;
    end
  end

endmodule

@@ hdl/rti_div.sv @@
module rti_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  rti_pkg::wide_t   num,
  input  rti_pkg::wide_t   den,
  output logic             done,
  output rti_pkg::coord_t  quo
);

  // restoring radix-2; den positive, quotient truncated toward zero
  logic                     run;
  logic                     first;
  logic                     neg;
  logic                     ovf;
  logic [rti_pkg::W-1:0]    r;
  logic [rti_pkg::W-1:0]    dsh;
  logic [rti_pkg::CB-1:0]   q;
  logic [rti_pkg::DCW-1:0]  cnt;
  logic                     ge;
  rti_pkg::coord_t          maxc;
  rti_pkg::coord_t          minc;

  assign ge = (r >= dsh);
  assign maxc = {1'b0, {(rti_pkg::CB-1){1'b1}}};
  assign minc = {1'b1, {(rti_pkg::CB-1){1'b0}}};

  always_comb begin
    if (ovf) quo = neg ? minc : maxc;
    else if (!neg) quo = q[rti_pkg::CB-1] ? maxc : q;
    else if (q[rti_pkg::CB-1] && |q[rti_pkg::CB-2:0]) quo = minc;
    else quo = ~q + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg <= num[rti_pkg::W-1];
      r <= num[rti_pkg::W-1] ? -num : num;
      dsh <= den << rti_pkg::CB;
      q <= '0;
      cnt <= rti_pkg::DCW'(rti_pkg::CB);
      first <= 1'b1;
    end else if (run) begin
      dsh <= dsh >> 1;
      if (first) begin
        ovf <= ge;
        first <= 1'b0;
      end else begin
        if (ge) r <= r - dsh;
        q <= {q[rti_pkg::CB-2:0], ge};
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && !first && cnt == rti_pkg::DCW'(1);
      if (go) run <= 1'b1;
      else if (run && !first && cnt == rti_pkg::DCW'(1)) run <= 1'b0;
    end
  end

endmodule

@@ hdl/rti_back.sv @@
module rti_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  rti_pkg::entry_t  entry,
  input  rti_pkg::coord_t  t_min,
  input  rti_pkg::coord_t  t_max,
  output logic             pop,
  output logic             done,
  output logic             hit,
  output rti_pkg::coord_t  ray_param,
  output rti_pkg::coord_t  bary_beta,
  output rti_pkg::coord_t  bary_gamma,
  output rti_pkg::coord_t  hit_x,
  output rti_pkg::coord_t  hit_y,
  output rti_pkg::coord_t  hit_z
);

  rti_pkg::state_t state;
  rti_pkg::state_t state_next;
  rti_pkg::entry_t cur;
  rti_pkg::phase_t ph;
  logic [1:0]      j;
  logic [1:0]      ti;
  logic [1:0]      idx;
  logic [1:0]      k;
  logic            lim;
  logic [1:0]      ca;
  logic [1:0]      cb;
  rti_pkg::wide_t  det [4];
  rti_pkg::wide_t  pprod;
  rti_pkg::wide_t  minor;
  rti_pkg::wide_t  tlo;
  rti_pkg::wide_t  thi;
  rti_pkg::wide_t  tsc;
  rti_pkg::coord_t qv [3];
  rti_pkg::coord_t hp [3];
  logic            hit_ok;

  logic            mul_go;
  rti_pkg::col_t   mul_a;
  rti_pkg::wide_t  mul_b;
  logic            mul_done;
  rti_pkg::wide_t  mul_prod;
  logic            div_go;
  rti_pkg::wide_t  div_num;
  logic            div_done;
  rti_pkg::coord_t div_quo;
  logic            emit;
  logic            emit_hit;

  rti_mul u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  rti_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(det[rti_pkg::DET_A]),
    .done(div_done), .quo(div_quo)
  );

  // matrix element of determinant jj at row r, column c
  function automatic rti_pkg::col_t mel(input rti_pkg::entry_t e, input logic [1:0] jj,
                                        input logic [1:0] r, input logic [1:0] c);
    logic [1:0] src;
    src = (jj != rti_pkg::DET_A && c == jj) ? rti_pkg::COL_AE : c;
    return e.col[src][r];
  endfunction

  assign ca = (ti == 2'd0) ? 2'd1 : 2'd0;
  assign cb = (ti == 2'd2) ? 2'd1 : 2'd2;
  assign tsc = det[rti_pkg::DET_T] <<< rti_pkg::FB;
  assign hit_ok = !(tsc < tlo) && !(tsc > thi)
                  && det[rti_pkg::DET_BETA] >= 0
                  && det[rti_pkg::DET_BETA] <= det[rti_pkg::DET_A]
                  && det[rti_pkg::DET_GAMMA] >= 0
                  && (det[rti_pkg::DET_BETA] + det[rti_pkg::DET_GAMMA]) <= det[rti_pkg::DET_A];

  always_ff @(posedge clk) begin
    if (rst) state <= rti_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    mul_go = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_go = 1'b0;
    div_num = '0;
    emit = 1'b0;
    emit_hit = 1'b0;
    unique case (state)
      rti_pkg::S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (entry.is_test) state_next = rti_pkg::S_DET;
          else emit = 1'b1;
        end
      end
      rti_pkg::S_DET: begin
        mul_go = 1'b1;
        case (ph)
          rti_pkg::PH_P: begin
            mul_a = mel(cur, j, 2'd1, ca);
            mul_b = rti_pkg::wext(mel(cur, j, 2'd2, cb));
          end
          rti_pkg::PH_Q: begin
            mul_a = mel(cur, j, 2'd2, ca);
            mul_b = rti_pkg::wext(mel(cur, j, 2'd1, cb));
          end
          default: begin
            mul_a = mel(cur, j, 2'd0, ti);
            mul_b = minor;
          end
        endcase
        state_next = rti_pkg::S_DETW;
      end
      rti_pkg::S_DETW: begin
        if (mul_done) begin
          if (ph == rti_pkg::PH_T && ti == 2'd2 && j == rti_pkg::DET_A)
            state_next = rti_pkg::S_SIGN;
          else state_next = rti_pkg::S_DET;
        end
      end
      rti_pkg::S_SIGN: begin
        if (det[rti_pkg::DET_A] == '0) begin
          emit = 1'b1;
          state_next = rti_pkg::S_IDLE;
        end else state_next = rti_pkg::S_LIM;
      end
      rti_pkg::S_LIM: begin
        mul_go = 1'b1;
        mul_a = lim ? rti_pkg::cext(t_max) : rti_pkg::cext(t_min);
        mul_b = det[rti_pkg::DET_A];
        state_next = rti_pkg::S_LIMW;
      end
      rti_pkg::S_LIMW: begin
        if (mul_done) state_next = lim ? rti_pkg::S_CHECK : rti_pkg::S_LIM;
      end
      rti_pkg::S_CHECK: begin
        if (hit_ok) state_next = rti_pkg::S_DIV;
        else begin
          emit = 1'b1;
          state_next = rti_pkg::S_IDLE;
        end
      end
      rti_pkg::S_DIV: begin
        div_go = 1'b1;
        if (idx == 2'd0) div_num = tsc;
        else if (idx == 2'd1) div_num = det[rti_pkg::DET_BETA] <<< rti_pkg::FB;
        else div_num = det[rti_pkg::DET_GAMMA] <<< rti_pkg::FB;
        state_next = rti_pkg::S_DIVW;
      end
      rti_pkg::S_DIVW: begin
        if (div_done) state_next = (idx == 2'd2) ? rti_pkg::S_HPT : rti_pkg::S_DIV;
      end
      rti_pkg::S_HPT: begin
        mul_go = 1'b1;
        mul_a = rti_pkg::cext(qv[0]);
        mul_b = rti_pkg::wext(cur.col[rti_pkg::COL_D][k]);
        state_next = rti_pkg::S_HPTW;
      end
      rti_pkg::S_HPTW: begin
        if (mul_done) state_next = (k == 2'd2) ? rti_pkg::S_OUT : rti_pkg::S_HPT;
      end
      rti_pkg::S_OUT: begin
        emit = 1'b1;
        emit_hit = 1'b1;
        state_next = rti_pkg::S_IDLE;
      end
      default: state_next = rti_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rti_pkg::S_IDLE: begin
        if (!empty) begin
          cur <= entry;
          j <= '0;
          ti <= '0;
          ph <= rti_pkg::PH_P;
          for (int n = 0; n < 4; n++) det[n] <= '0;
        end
      end
      rti_pkg::S_DETW: begin
        if (mul_done) begin
          case (ph)
            rti_pkg::PH_P: begin
              pprod <= mul_prod;
              ph <= rti_pkg::PH_Q;
            end
            rti_pkg::PH_Q: begin
              minor <= pprod - mul_prod;
              ph <= rti_pkg::PH_T;
            end
            default: begin
              if (ti == 2'd1) det[j] <= det[j] - mul_prod;
              else det[j] <= det[j] + mul_prod;
              ph <= rti_pkg::PH_P;
              if (ti == 2'd2) begin
                ti <= '0;
                j <= j + 2'd1;
              end else ti <= ti + 2'd1;
            end
          endcase
        end
      end
      rti_pkg::S_SIGN: begin
        lim <= 1'b0;
        if (det[rti_pkg::DET_A][rti_pkg::W-1])
          for (int n = 0; n < 4; n++) det[n] <= -det[n];
      end
      rti_pkg::S_LIMW: begin
        if (mul_done) begin
          if (lim) thi <= mul_prod;
          else tlo <= mul_prod;
          lim <= 1'b1;
        end
      end
      rti_pkg::S_CHECK: idx <= '0;
      rti_pkg::S_DIVW: begin
        if (div_done) begin
          qv[idx] <= div_quo;
          idx <= idx + 2'd1;
          k <= '0;
        end
      end
      rti_pkg::S_HPTW: begin
        if (mul_done) begin
          hp[k] <= rti_pkg::sat((mul_prod >>> rti_pkg::FB)
                   + rti_pkg::wext(rti_pkg::cext(cur.pos[k])));
          k <= k + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= emit;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hit <= emit_hit;
      ray_param <= emit_hit ? qv[0] : '0;
      bary_beta <= emit_hit ? qv[1] : '0;
      bary_gamma <= emit_hit ? qv[2] : '0;
      hit_x <= emit_hit ? hp[0] : '0;
      hit_y <= emit_hit ? hp[1] : '0;
      hit_z <= emit_hit ? hp[2] : '0;
    end
  end

endmodule

@@ hdl/ray_triangle_intersect.sv @@
// Ray-triangle test by Cramer's rule in signed Q16.16. Items enter on start
// while busy is low and land in a two-entry queue; one result per item comes
// back in order on done, one cycle wide, with no back-pressure. A load is
// retired once it is at the head of the queue. A ray test runs four 3x3
// determinants (36 products) through one shared multiplier that takes 8 bits
// of a factor per cycle. A hit adds three 32-step radix-2 divisions and the
// hit point. Zero determinant reads as a miss.
module ray_triangle_intersect (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             opcode,
  input  logic [1:0]       vertex_slot,
  input  rti_pkg::coord_t  pos_x,
  input  rti_pkg::coord_t  pos_y,
  input  rti_pkg::coord_t  pos_z,
  input  rti_pkg::coord_t  dir_x,
  input  rti_pkg::coord_t  dir_y,
  input  rti_pkg::coord_t  dir_z,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [rti_pkg::CB-1:0] cfg_data,
  output logic             done,
  output logic             hit,
  output rti_pkg::coord_t  ray_param,
  output rti_pkg::coord_t  bary_beta,
  output rti_pkg::coord_t  bary_gamma,
  output rti_pkg::coord_t  hit_x,
  output rti_pkg::coord_t  hit_y,
  output rti_pkg::coord_t  hit_z
);

  localparam rti_pkg::coord_t ONE_Q = rti_pkg::coord_t'(1) << rti_pkg::FB;

  rti_pkg::coord_t t_min;
  rti_pkg::coord_t t_max;
  rti_pkg::entry_t q_in;
  rti_pkg::entry_t q_out;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_min <= '0;
      t_max <= rti_pkg::TMAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::CFG_TMIN: t_min <= cfg_data;
        rti_pkg::CFG_TMAX: t_max <= cfg_data;
      endcase
    end
  end

  rti_front u_front (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .vertex_slot(vertex_slot),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .full(full), .busy(busy), .push(push), .ent(q_in)
  );

  rti_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(q_in), .pop(pop),
    .dout(q_out), .full(full), .empty(empty)
  );

  rti_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .entry(q_out), .t_min(t_min), .t_max(t_max),
    .pop(pop), .done(done), .hit(hit), .ray_param(ray_param),
    .bary_beta(bary_beta), .bary_gamma(bary_gamma),
    .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
  );

  a_bary_range: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> bary_beta >= 0 && bary_gamma >= 0 && bary_beta <= ONE_Q
                    && (bary_beta + bary_gamma) <= ONE_Q)
    else $error("barycentrics out of range on a hit");

  a_t_window: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> ray_param >= t_min && ray_param <= t_max)
    else $error("ray parameter outside limits on a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> ray_param == 0 && bary_beta == 0 && bary_gamma == 0
                     && hit_x == 0 && hit_y == 0 && hit_z == 0)
    else $error("nonzero fields on a miss transfer");

endmodule

@@ dv/ray_triangle_checker.sv @@
module ray_triangle_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   opcode,
  input  logic [1:0]             vertex_slot,
  input  rti_pkg::coord_t        pos_x,
  input  rti_pkg::coord_t        pos_y,
  input  rti_pkg::coord_t        pos_z,
  input  rti_pkg::coord_t        dir_x,
  input  rti_pkg::coord_t        dir_y,
  input  rti_pkg::coord_t        dir_z,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [rti_pkg::CB-1:0] cfg_data,
  input  logic                   done,
  input  logic                   hit,
  input  rti_pkg::coord_t        ray_param,
  input  rti_pkg::coord_t        bary_beta,
  input  rti_pkg::coord_t        bary_gamma,
  input  rti_pkg::coord_t        hit_x,
  input  rti_pkg::coord_t        hit_y,
  input  rti_pkg::coord_t        hit_z,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic            hit;
    rti_pkg::coord_t t;
    rti_pkg::coord_t beta;
    rti_pkg::coord_t gamma;
    rti_pkg::coord_t px;
    rti_pkg::coord_t py;
    rti_pkg::coord_t pz;
  } isect_t;

  rti_pkg::coord_t vtx [9];
  rti_pkg::coord_t t_lo;
  rti_pkg::coord_t t_hi;
  isect_t isect_q [$];

  function automatic rti_pkg::coord_t clamp(input big_t v);
    big_t hi;
    big_t lo;
    hi = 256'sd2147483647;
    lo = -256'sd2147483648;
    if (v > hi) return 32'h7fffffff;
    if (v < lo) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic big_t det3(input big_t m [9]);
    big_t k0;
    big_t k1;
    big_t k2;
    k0 = m[4] * m[8] - m[7] * m[5];
    k1 = m[3] * m[8] - m[6] * m[5];
    k2 = m[3] * m[7] - m[6] * m[4];
    return m[0] * k0 - m[1] * k1 + m[2] * k2;
  endfunction

  function automatic isect_t predict(input rti_pkg::coord_t e [3],
                                     input rti_pkg::coord_t d [3]);
    isect_t r;
    big_t col [4][3];
    big_t m [9];
    big_t det [4];
    big_t a;
    big_t tsc;
    big_t ev;
    big_t dv;
    big_t p;
    big_t tmin_b;
    big_t tmax_b;
    int src;
    r = '{default: '0};
    for (int k = 0; k < 3; k++) begin
      a = vtx[k];
      col[0][k] = a - big_t'(vtx[3+k]);
      col[1][k] = a - big_t'(vtx[6+k]);
      col[2][k] = d[k];
      col[3][k] = a - big_t'(e[k]);
    end
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          src = (j < 3 && c == j) ? 3 : c;
          m[k*3+c] = col[src][k];
        end
      end
      det[j] = det3(m);
    end
    // det[3] is the system determinant; a zero one is a miss
    if (det[3] == 0) return r;
    if (det[3] < 0)
      for (int j = 0; j < 4; j++) det[j] = -det[j];
    tsc = det[2] <<< rti_pkg::FB;
    tmin_b = t_lo;
    tmax_b = t_hi;
    if (tsc < tmin_b * det[3] || tsc > tmax_b * det[3]) return r;
    if (det[0] < 0 || det[0] > det[3]) return r;
    if (det[1] < 0 || det[0] + det[1] > det[3]) return r;
    r.hit = 1'b1;
    r.t = clamp(tsc / det[3]);
    r.beta = clamp((det[0] <<< rti_pkg::FB) / det[3]);
    r.gamma = clamp((det[1] <<< rti_pkg::FB) / det[3]);
    for (int k = 0; k < 3; k++) begin
      ev = e[k];
      dv = d[k];
      p = big_t'(r.t) * dv;
      p = p >>> rti_pkg::FB;
      if (k == 0) r.px = clamp(p + ev);
      else if (k == 1) r.py = clamp(p + ev);
      else r.pz = clamp(p + ev);
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    isect_t r;
    isect_t w;
    rti_pkg::coord_t e [3];
    rti_pkg::coord_t d [3];
    if (rst) begin
      for (int i = 0; i < 9; i++) vtx[i] = '0;
      t_lo = '0;
      t_hi = rti_pkg::TMAX_RST;
      isect_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (isect_q.size() == 0) begin
          report("unexpected transfer, hit", {31'd0, hit}, 32'd0);
        end else begin
          w = isect_q.pop_front();
          if (hit !== w.hit) report("hit", {31'd0, hit}, {31'd0, w.hit});
          if (ray_param !== w.t) report("ray_param", ray_param, w.t);
          if (bary_beta !== w.beta) report("bary_beta", bary_beta, w.beta);
          if (bary_gamma !== w.gamma) report("bary_gamma", bary_gamma, w.gamma);
          if (hit_x !== w.px) report("hit_x", hit_x, w.px);
          if (hit_y !== w.py) report("hit_y", hit_y, w.py);
          if (hit_z !== w.pz) report("hit_z", hit_z, w.pz);
        end
      end
      if (cfg_we) begin
        if (cfg_index == rti_pkg::CFG_TMIN) t_lo = cfg_data;
        else t_hi = cfg_data;
      end
      if (start && !busy) begin
        r = '{default: '0};
        if (opcode == rti_pkg::OP_LOAD) begin
          if (vertex_slot != rti_pkg::SLOT_NONE) begin
            vtx[vertex_slot*3] = pos_x;
            vtx[vertex_slot*3+1] = pos_y;
            vtx[vertex_slot*3+2] = pos_z;
          end
        end else begin
          e = '{pos_x, pos_y, pos_z};
          d = '{dir_x, dir_y, dir_z};
          r = predict(e, d);
        end
        isect_q = {isect_q, r};
      end
    end
    pending <= isect_q.size();
  end

endmodule

@@ dv/ray_triangle_intersect_tb.sv @@
module ray_triangle_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1 << rti_pkg::FB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = rti_pkg::OP_LOAD;
  logic [1:0] vertex_slot = rti_pkg::SLOT_A;
  rti_pkg::coord_t pos_x = '0, pos_y = '0, pos_z = '0;
  rti_pkg::coord_t dir_x = '0, dir_y = '0, dir_z = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = rti_pkg::CFG_TMIN;
  logic [rti_pkg::CB-1:0] cfg_data = '0;
  logic done, hit;
  rti_pkg::coord_t ray_param, bary_beta, bary_gamma, hit_x, hit_y, hit_z;
  int fail_count, pending;
  int sent = 0;
  bit calm = 0;

  always #4 clk = ~clk;

  ray_triangle_intersect dut (.*);
  ray_triangle_checker chk (.*);

  task automatic send(input logic op, input logic [1:0] slot,
                      input rti_pkg::coord_t px, input rti_pkg::coord_t py,
                      input rti_pkg::coord_t pz, input rti_pkg::coord_t dx,
                      input rti_pkg::coord_t dy, input rti_pkg::coord_t dz);
    if (!calm && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    vertex_slot <= slot;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input rti_pkg::coord_t lo, input rti_pkg::coord_t hi);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= rti_pkg::CFG_TMIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= rti_pkg::CFG_TMAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load(input logic [1:0] slot, input rti_pkg::coord_t x,
                      input rti_pkg::coord_t y, input rti_pkg::coord_t z);
    send(rti_pkg::OP_LOAD, slot, x, y, z, rti_pkg::coord_t'($urandom),
         rti_pkg::coord_t'($urandom), rti_pkg::coord_t'($urandom));
  endtask

  // small triangle, then rays aimed at points inside or near it
  task automatic aimed_group();
    rti_pkg::coord_t v [3][3];
    rti_pkg::coord_t e [3];
    rti_pkg::coord_t d [3];
    longint p;
    int u, w, sh;
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) v[s][k] = $signed($urandom_range(0, 200 * ONE)) - 100 * ONE;
      load(s[1:0], v[s][0], v[s][1], v[s][2]);
    end
    repeat ($urandom_range(2, 6)) begin
      u = $urandom_range(0, ONE + 4000) - 2000;
      w = $urandom_range(0, ONE + 4000 - u) - 2000;
      sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        p = longint'(v[0][k]) + ((longint'(u) * (v[1][k] - v[0][k])
            + longint'(w) * (v[2][k] - v[0][k])) >>> rti_pkg::FB);
        e[k] = $signed($urandom_range(0, 200 * ONE)) - 100 * ONE;
        d[k] = rti_pkg::coord_t'((p - e[k]) >>> sh);
        if ($urandom_range(0, 3) == 0) d[k] = -d[k];
      end
      send(rti_pkg::OP_TEST, 2'($urandom_range(0, 3)), e[0], e[1], e[2], d[0], d[1], d[2]);
    end
  endtask

  task automatic noise_item();
    send(logic'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
         rti_pkg::coord_t'($urandom), rti_pkg::coord_t'($urandom),
         rti_pkg::coord_t'($urandom), rti_pkg::coord_t'($urandom),
         rti_pkg::coord_t'($urandom), rti_pkg::coord_t'($urandom));
  endtask

  task automatic random_phase(input int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(0, 9) < 8) aimed_group();
      else noise_item();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE, ONE, ONE, 0, 0, -ONE);
    load(rti_pkg::SLOT_A, 32'h80000000, 32'h7fffffff, 32'h80000000);
    load(rti_pkg::SLOT_B, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    load(rti_pkg::SLOT_NONE, ONE, ONE, ONE);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, 32'h7fffffff, 32'h80000000, 0,
         32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_C, 32'hffffffff, 0, 32'h7fffffff, 1,
         32'hffffffff, 32'h80000000);
    load(rti_pkg::SLOT_A, 0, 0, 0);
    load(rti_pkg::SLOT_B, ONE, 0, 0);
    load(rti_pkg::SLOT_C, 0, ONE, 0);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, ONE, 0, 0, -ONE);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, 0, ONE / 2, ONE, 0, 0, -ONE);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 2, ONE / 2, ONE, 0, 0, -ONE);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, ONE, 0, 0, ONE);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, ONE, ONE, 0, 0);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, 2 * ONE, 2 * ONE, ONE, 0, 0, -ONE);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, 32'h7fff0000, 0, 0, -1);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, 32'h7fff0000,
         32'h7fffffff, 32'h7fffffff, -2);
    set_limits(32'h80000000, 32'h7fffffff);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, 32'h7fff0000,
         32'h7fffffff, 32'h80000000, -2);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, 32'h7fff0000, 0, 0, -1);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, ONE, 0, 0, ONE);
    set_limits(2 * ONE, ONE);
    send(rti_pkg::OP_TEST, rti_pkg::SLOT_A, ONE / 4, ONE / 4, ONE, 0, 0, -ONE);
    set_limits(0, 1000 * ONE);
    random_phase(500);
    set_limits(32'h80000000, 32'h7fffffff);
    random_phase(400);
    drain();
    random_phase(100);
    set_limits(ONE, 3 * ONE);
    random_phase(300);
    set_limits(200 * ONE, 32'h80000000);
    random_phase(100);
    set_limits(-1000 * ONE, 2000 * ONE);
    random_phase(250);
    calm = 1;
    random_phase(250);
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("ray_triangle_intersect: match");
    else $display("ray_triangle_intersect: mismatch");
    $finish;
  end

  initial begin
    #40ms;
    $display("ray_triangle_intersect: mismatch");
    $finish;
  end

endmodule

@@ ray_triangle_intersect.f @@
hdl/rti_pkg.sv
hdl/rti_front.sv
hdl/rti_queue.sv
hdl/rti_mul.sv
hdl/rti_div.sv
hdl/rti_back.sv
hdl/ray_triangle_intersect.sv
dv/ray_triangle_checker.sv
dv/ray_triangle_intersect_tb.sv
